FILE: src/rts_pkg.sv
// shared types and constants for the ribbon trail segment block
`timescale 1ns / 1ps
package rts_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned HW_RAW = ((1 << FRAC_BITS) * 8 + 500) / 1000;
  localparam int unsigned HALF_WIDTH_RESET = (HW_RAW > 65535) ? 65535 : HW_RAW;

  typedef logic signed [31:0] coord_t;
  typedef coord_t [2:0] vec_t;
  typedef logic signed [18:0] off_t;
  typedef off_t [2:0] off_vec_t;

  typedef struct packed {
    logic        first;
    vec_t        point;
    vec_t        cam;
    vec_t        prior;
    logic [15:0] hw;
  } rts_req_t;

endpackage

FILE: src/rts_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module rts_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);
  logic signed [65:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;
endmodule

FILE: src/rts_core.sv
// sequencer for cross product, normalization, square root and division
`timescale 1ns / 1ps
module rts_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  rts_pkg::rts_req_t req_i,
  input  logic              ack_i,
  output logic              done_o,
  output rts_pkg::off_vec_t off_o
);
  import rts_pkg::*;

  typedef enum logic [3:0] {
    IDLE, FIT, MUL, MAG, NORM, SQ, SQRT, DMUL, DLOAD, DIV, DONE
  } state_e;

  state_e             state_q;
  logic [4:0]         cnt_q;
  logic [1:0]         idx_q;
  logic signed [32:0] d_q [3];
  logic signed [32:0] l_q [3];
  logic signed [63:0] c_q [3];
  logic [61:0]        m_q [3];
  logic [2:0]         neg_q;
  logic [63:0]        acc_q;
  logic [63:0]        res_q;
  logic [63:0]        bit_q;
  logic [50:0]        rem_q;
  logic [50:0]        dsh_q;
  logic [17:0]        quo_q;
  logic [15:0]        hw_q;
  off_vec_t           off_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic               big_d, big_l, any_hi, any_b30, c_zero, ge;
  logic [64:0]        trial;
  logic [17:0]        quo_n;

  function automatic logic [32:0] mag33(logic signed [32:0] v);
    mag33 = v[32] ? (~v + 33'd1) : v;
  endfunction

  function automatic logic signed [32:0] half_tz(logic signed [32:0] v);
    logic [32:0] m;
    m = mag33(v) >> 1;
    half_tz = v[32] ? -$signed(m) : $signed(m);
  endfunction

  rts_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      MUL: begin
        unique case (cnt_q)
          5'd0: begin mul_a = d_q[1]; mul_b = l_q[2]; end
          5'd1: begin mul_a = d_q[2]; mul_b = l_q[1]; end
          5'd2: begin mul_a = d_q[2]; mul_b = l_q[0]; end
          5'd3: begin mul_a = d_q[0]; mul_b = l_q[2]; end
          5'd4: begin mul_a = d_q[0]; mul_b = l_q[1]; end
          5'd5: begin mul_a = d_q[1]; mul_b = l_q[0]; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      SQ: begin
        if (cnt_q < 5'd3) begin
          mul_a = $signed({2'b00, m_q[cnt_q[1:0]][30:0]});
          mul_b = $signed({2'b00, m_q[cnt_q[1:0]][30:0]});
        end
      end
      DMUL: begin
        mul_a = $signed({2'b00, m_q[idx_q][30:0]});
        mul_b = $signed({17'd0, hw_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    big_d = 1'b0;
    big_l = 1'b0;
    any_hi = 1'b0;
    any_b30 = 1'b0;
    c_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      big_d = big_d | (mag33(d_q[i]) > 33'h040000000);
      big_l = big_l | (mag33(l_q[i]) > 33'h040000000);
      any_hi = any_hi | (m_q[i][61:31] != '0);
      any_b30 = any_b30 | m_q[i][30];
      c_zero = c_zero & (c_q[i] == '0);
    end
    trial = {1'b0, res_q} + {1'b0, bit_q};
    ge = (rem_q >= dsh_q);
    quo_n = {quo_q[16:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        IDLE: begin
          if (start_i) begin
            hw_q <= req_i.hw;
            for (int i = 0; i < 3; i++) begin
              d_q[i] <= $signed({req_i.prior[i][31], req_i.prior[i]})
                      - $signed({req_i.point[i][31], req_i.point[i]});
              l_q[i] <= $signed({req_i.cam[i][31], req_i.cam[i]})
                      - $signed({req_i.point[i][31], req_i.point[i]});
            end
            if (req_i.first) begin
              off_q   <= '0;
              state_q <= DONE;
            end else begin
              state_q <= FIT;
            end
          end
        end
        FIT: begin
          for (int i = 0; i < 3; i++) begin
            if (big_d) d_q[i] <= half_tz(d_q[i]);
            if (big_l) l_q[i] <= half_tz(l_q[i]);
          end
          if (!big_d && !big_l) begin
            cnt_q   <= '0;
            state_q <= MUL;
          end
        end
        MUL: begin
          cnt_q <= cnt_q + 5'd1;
          unique case (cnt_q)
            5'd1: c_q[0] <= prod[63:0];
            5'd2: c_q[0] <= c_q[0] - prod[63:0];
            5'd3: c_q[1] <= prod[63:0];
            5'd4: c_q[1] <= c_q[1] - prod[63:0];
            5'd5: c_q[2] <= prod[63:0];
            5'd6: begin
              c_q[2]  <= c_q[2] - prod[63:0];
              state_q <= MAG;
            end
            default: ;
          endcase
        end
        MAG: begin
          for (int i = 0; i < 3; i++) begin
            m_q[i]   <= c_q[i][63] ? 62'(-c_q[i]) : c_q[i][61:0];
            neg_q[i] <= c_q[i][63];
          end
          if (c_zero) begin
            off_q   <= '0;
            state_q <= DONE;
          end else begin
            state_q <= NORM;
          end
        end
        NORM: begin
          // bring the largest magnitude into [2^30, 2^31)
          priority if (any_hi) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
          end else if (!any_b30) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
          end else begin
            acc_q   <= '0;
            cnt_q   <= '0;
            state_q <= SQ;
          end
        end
        SQ: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q != 5'd0) acc_q <= acc_q + prod[63:0];
          if (cnt_q == 5'd3) begin
            res_q   <= '0;
            bit_q   <= 64'h4000_0000_0000_0000;
            cnt_q   <= '0;
            state_q <= SQRT;
          end
        end
        SQRT: begin
          if ({1'b0, acc_q} >= trial) begin
            acc_q <= acc_q - trial[63:0];
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            idx_q   <= '0;
            state_q <= DMUL;
          end
        end
        DMUL: state_q <= DLOAD;
        DLOAD: begin
          rem_q   <= {3'd0, prod[47:0]} + {19'd0, res_q[32:1]};
          dsh_q   <= {1'b0, res_q[32:0], 17'd0};
          quo_q   <= '0;
          cnt_q   <= '0;
          state_q <= DIV;
        end
        DIV: begin
          if (ge) rem_q <= rem_q - dsh_q;
          dsh_q <= dsh_q >> 1;
          quo_q <= quo_n;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd17) begin
            off_q[idx_q] <= neg_q[idx_q] ? -$signed({1'b0, quo_n})
                                         : $signed({1'b0, quo_n});
            if (idx_q == 2'd2) begin
              state_q <= DONE;
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= DMUL;
            end
          end
        end
        DONE: begin
          if (ack_i) state_q <= IDLE;
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign done_o = (state_q == DONE);
  assign off_o  = off_q;
endmodule

FILE: src/ribbon_trail_segment.sv
// top level: stream ports, trail state, corner saturation and output register
// a first point skips the computation; otherwise the core runs edge fit,
// cross product, normalize, squares, square root and three divisions, in
// that order, with the shared multiplier and one-bit-per-cycle sqrt/divide;
// one item at a time, ready while idle
// rst_ni clears control state, trail state and sets half_width to 524
`timescale 1ns / 1ps
module ribbon_trail_segment (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,    // half_width
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // point_x, point_y, point_z, camera_x, camera_y, camera_z
  input  logic [191:0]  s_axis_tdata,
  input  logic          s_axis_tuser,   // restart
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // cur_right_x/y/z, cur_left_x/y/z, old_right_x/y/z, old_left_x/y/z
  output logic [383:0]  m_axis_tdata
);
  import rts_pkg::*;

  logic        busy_q, first_q, have_prior_q, m_valid_q;
  logic [15:0] hw_q;
  vec_t        p_q, prior_pt_q, prior_r_q, prior_l_q;
  logic [383:0] m_data_q;

  logic        s_acc, core_done, load;
  rts_req_t    req;
  off_vec_t    off;
  vec_t        cr, cl, orr, ol;

  function automatic coord_t sat32(logic signed [32:0] v);
    if (v > 33'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -33'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  assign s_acc = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = !busy_q;
  assign load = core_done & (!m_valid_q | m_axis_tready);

  always_comb begin
    req.first = s_axis_tuser | !have_prior_q;
    req.hw    = hw_q;
    req.prior = prior_pt_q;
    for (int i = 0; i < 3; i++) begin
      req.point[i] = s_axis_tdata[32*i +: 32];
      req.cam[i]   = s_axis_tdata[96 + 32*i +: 32];
    end
    for (int i = 0; i < 3; i++) begin
      cr[i]  = sat32($signed({p_q[i][31], p_q[i]}) + 33'(off[i]));
      cl[i]  = sat32($signed({p_q[i][31], p_q[i]}) - 33'(off[i]));
      orr[i] = first_q ? p_q[i] : prior_r_q[i];
      ol[i]  = first_q ? p_q[i] : prior_l_q[i];
    end
  end

  rts_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s_acc),
    .req_i   (req),
    .ack_i   (load),
    .done_o  (core_done),
    .off_o   (off)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      first_q      <= 1'b0;
      have_prior_q <= 1'b0;
      m_valid_q    <= 1'b0;
      hw_q         <= 16'(HALF_WIDTH_RESET);
      prior_pt_q   <= '0;
      prior_r_q    <= '0;
      prior_l_q    <= '0;
    end else begin
      if (cfg_we_i) hw_q <= cfg_wdata_i;
      if (s_acc) begin
        busy_q  <= 1'b1;
        first_q <= req.first;
        p_q     <= req.point;
      end
      if (load) begin
        busy_q       <= 1'b0;
        m_valid_q    <= 1'b1;
        m_data_q     <= {ol, orr, cl, cr};
        prior_pt_q   <= p_q;
        prior_r_q    <= cr;
        prior_l_q    <= cl;
        have_prior_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready) else $error("ready after accepted transaction");
  a_done_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_done |-> busy_q) else $error("core result without pending transaction");
  a_first_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && first_q |=> m_axis_tdata[31:0] == m_axis_tdata[223:192])
    else $error("first point quad not flat");
`endif
endmodule
